// ===== hw/rtl/lpbm_pkg.sv =====
// Package for the LRU page buffer manager: sizes, transaction structs and
// the command/status groups between controller and datapath. No dependencies.
package lpbm_pkg;

   localparam int NUM_FRAMES  = 1024;
   localparam int NUM_PAGES   = 65536;
   localparam int FRAME_W     = $clog2(NUM_FRAMES);
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int FRAME_OUT_W = 10;
   localparam int PAGE_OUT_W  = 16;

   // request modes
   localparam logic MODE_FIX   = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [PAGE_OUT_W-1:0] page_id;
      logic                  write_access;
   } req_type;

   typedef struct packed {
      logic [FRAME_OUT_W-1:0] frame_num;
      logic [PAGE_OUT_W-1:0]  page_held;
      logic                   hit;
      logic                   fetch_needed;
      logic                   evict_valid;
      logic [PAGE_OUT_W-1:0]  evict_page;
      logic                   writeback_needed;
      logic                   status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic decide;
      logic unlink;
      logic append;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic alloc_full;
   } stat_type;

endpackage

// ===== hw/rtl/lpbm_datapath.sv =====
// Datapath of the page buffer manager: page map, frame tables, LRU links,
// counters and result register. Depends on lpbm_pkg.
module lpbm_datapath
   import lpbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   // memories
   logic [FRAME_W:0]   map_mem   [NUM_PAGES];
   logic [PAGE_W-1:0]  page_mem  [NUM_FRAMES];
   logic               dirty_mem [NUM_FRAMES];
   logic [FRAME_W-1:0] next_mem  [NUM_FRAMES];
   logic [FRAME_W-1:0] prev_mem  [NUM_FRAMES];

   // registered read data
   logic [FRAME_W:0]   map_rd_ff;
   logic [PAGE_W-1:0]  page_rd_ff;
   logic               dirty_rd_ff;
   logic [FRAME_W-1:0] nxt_rd_ff;
   logic [FRAME_W-1:0] prv_rd_ff;

   // transaction context
   logic [PAGE_W-1:0]  p_ff, p_in;
   logic               dirty_ff, dirty_in;
   logic               fetch_ff, fetch_in;
   logic               err_ff, err_in;
   logic               hit_ff;
   logic               evict_ff;
   logic [FRAME_W-1:0] f_ff;
   logic [PAGE_W-1:0]  evpage_ff;
   logic               wb_ff;
   rsp_type            rsp_ff, rsp_in;

   // control state
   logic [FRAME_W-1:0] head_ff, tail_ff;
   logic [FRAME_W:0]   frames_cnt_ff;
   logic [PAGE_W:0]    pages_cnt_ff;
   logic [PAGE_W-1:0]  clr_ff;

   logic list_one;      // append onto an empty list
   logic link_mid;      // hit frame sits strictly inside the list
   logic hit_relink;    // hit with at least two frames in the list

   assign stat.clear_last = (clr_ff == PAGE_W'(NUM_PAGES - 1));
   assign stat.alloc_full = (req_data.mode == MODE_ALLOC) &&
                            (pages_cnt_ff == (PAGE_W+1)'(NUM_PAGES));

   assign hit_relink = hit_ff && (frames_cnt_ff >= (FRAME_W+1)'(2));
   assign link_mid   = hit_relink && (f_ff != head_ff) && (f_ff != tail_ff);
   assign list_one   = (!hit_ff && (frames_cnt_ff == '0)) ||
                       (hit_ff && (frames_cnt_ff == (FRAME_W+1)'(1)));

   // request decode
   always_comb begin
      p_in     = req_data.page_id[PAGE_W-1:0];
      dirty_in = req_data.write_access;
      fetch_in = 1'b1;
      err_in   = 1'b0;
      if (req_data.mode == MODE_ALLOC) begin
         p_in     = pages_cnt_ff[PAGE_W-1:0];
         dirty_in = 1'b1;
         fetch_in = 1'b0;
         err_in   = stat.alloc_full;
      end
   end

   // memory reads, one per memory per cycle
   always_ff @(posedge clock) begin
      map_rd_ff   <= map_mem[p_ff];
      page_rd_ff  <= page_mem[f_ff];
      dirty_rd_ff <= dirty_mem[f_ff];
      nxt_rd_ff   <= next_mem[f_ff];
      prv_rd_ff   <= prev_mem[f_ff];
   end

   // page map write port
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         map_mem[clr_ff] <= '0;
      end else if (cmd.unlink && evict_ff) begin
         map_mem[page_rd_ff] <= '0;
      end else if (cmd.append && !hit_ff) begin
         map_mem[p_ff] <= {1'b1, f_ff};
      end
   end

   // frame table writes
   always_ff @(posedge clock) begin
      if (cmd.append && !hit_ff) begin
         page_mem[f_ff] <= p_ff;
      end
      if (cmd.append && (!hit_ff || dirty_ff)) begin
         dirty_mem[f_ff] <= dirty_ff;
      end
   end

   // LRU link writes
   always_ff @(posedge clock) begin
      if (cmd.unlink && link_mid) begin
         next_mem[prv_rd_ff] <= nxt_rd_ff;
      end else if (cmd.append && !list_one) begin
         next_mem[tail_ff] <= f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.unlink && link_mid) begin
         prev_mem[nxt_rd_ff] <= prv_rd_ff;
      end else if (cmd.append && !list_one) begin
         prev_mem[f_ff] <= tail_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         frames_cnt_ff <= '0;
         pages_cnt_ff  <= '0;
         clr_ff        <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load_req && (req_data.mode == MODE_ALLOC) && !stat.alloc_full) begin
            pages_cnt_ff <= pages_cnt_ff + 1'b1;
         end
         if (cmd.unlink) begin
            if (evict_ff) begin
               head_ff <= nxt_rd_ff;
            end else if (hit_relink) begin
               priority if (f_ff == head_ff) begin
                  head_ff <= nxt_rd_ff;
               end else if (f_ff == tail_ff) begin
                  tail_ff <= prv_rd_ff;
               end else begin
                  // middle frame: list ends stay put
                  head_ff <= head_ff;
               end
            end
         end
         if (cmd.append) begin
            if (list_one) begin
               head_ff <= f_ff;
            end
            tail_ff <= f_ff;
            if (!hit_ff && !evict_ff) begin
               frames_cnt_ff <= frames_cnt_ff + 1'b1;
            end
         end
      end
   end

   // result assembly
   always_comb begin
      rsp_in = '0;
      if (err_ff) begin
         rsp_in.status = 1'b1;
      end else begin
         rsp_in.frame_num        = FRAME_OUT_W'(f_ff);
         rsp_in.page_held        = PAGE_OUT_W'(p_ff);
         rsp_in.hit              = hit_ff;
         rsp_in.fetch_needed     = !hit_ff && fetch_ff;
         rsp_in.evict_valid      = !hit_ff && evict_ff;
         rsp_in.evict_page       = (!hit_ff && evict_ff) ? PAGE_OUT_W'(evpage_ff) : '0;
         rsp_in.writeback_needed = !hit_ff && evict_ff && wb_ff;
      end
   end

   // transaction context and result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         p_ff     <= p_in;
         dirty_ff <= dirty_in;
         fetch_ff <= fetch_in;
         err_ff   <= err_in;
         hit_ff   <= 1'b0;
         evict_ff <= 1'b0;
         wb_ff    <= 1'b0;
      end
      if (cmd.decide) begin
         hit_ff <= map_rd_ff[FRAME_W];
         if (map_rd_ff[FRAME_W]) begin
            f_ff     <= map_rd_ff[FRAME_W-1:0];
            evict_ff <= 1'b0;
         end else if (frames_cnt_ff < (FRAME_W+1)'(NUM_FRAMES)) begin
            f_ff     <= frames_cnt_ff[FRAME_W-1:0];
            evict_ff <= 1'b0;
         end else begin
            f_ff     <= head_ff;
            evict_ff <= 1'b1;
         end
      end
      if (cmd.unlink) begin
         evpage_ff <= page_rd_ff;
         wb_ff     <= dirty_rd_ff;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/lpbm_ctrl.sv =====
// Controller of the page buffer manager: sequences map clear, lookup, LRU
// relink and result hand-off. Depends on lpbm_pkg.
module lpbm_ctrl
   import lpbm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_MAP    = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_LINK   = 8'b0001_0000,
      ST_UNLINK = 8'b0010_0000,
      ST_APPEND = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd          = '0;
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.load_req = accept;
      cmd.decide   = (state_ff == ST_DECIDE);
      cmd.unlink   = (state_ff == ST_UNLINK);
      cmd.append   = (state_ff == ST_APPEND);
      cmd.load_rsp = (state_ff == ST_DONE) && slot_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = stat.alloc_full ? ST_DONE : ST_MAP;
         ST_MAP:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_LINK;
         ST_LINK:   state_in = ST_UNLINK;
         ST_UNLINK: state_in = ST_APPEND;
         ST_APPEND: state_in = ST_DONE;
         ST_DONE:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/lru_page_buffer_manager_unit.sv =====
// Top level of the LRU page buffer manager: controller plus datapath.
// Depends on lpbm_pkg, lpbm_ctrl and lpbm_datapath.
//
// Buffer pool that maps page ids onto 1024 frames with least-recently-used
// replacement. After reset the page map is cleared one entry per cycle, so
// no transaction is taken until all 65536 entries are clear. Afterwards one
// transaction is handled at a time: a fix or allocate steps through page
// map lookup, decide, link read, unlink and append before its result is
// presented, and the next transaction is taken once the result register
// is free (an allocate with no free page skips to the result). Steps are set
// by the chain of dependent single-port memory accesses: page map lookup,
// link and frame table read, unlink write, append write. The result sits in
// an output register while the next transaction is accepted; if that result
// is still stalled when the next one finishes, the input stalls as well.
module lru_page_buffer_manager_unit
   import lpbm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   lpbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpbm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // busy right after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a transaction back to back");

   // a hit never fetches or evicts
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (!rsp_data.fetch_needed && !rsp_data.evict_valid))
      else $error("hit with fetch or eviction");

   // writeback only with an eviction
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.writeback_needed) |-> rsp_data.evict_valid)
      else $error("writeback without eviction");

   // error result carries nothing else
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |->
         (!rsp_data.hit && !rsp_data.fetch_needed && !rsp_data.evict_valid &&
          rsp_data.page_held == '0))
      else $error("error result with payload");

endmodule
